// File: hw/rtl/cjt_pkg.sv
// Package with shared widths and defaults of the cubic joint trajectory block.
`default_nettype none
package cjt_pkg;
  localparam int JointsDefault = 6;
  localparam int DataW = 32;
  localparam int JointFieldW = 3;
  localparam int DivNumW = 67;
  localparam int DivDenW = 33;
  localparam logic [DataW-1:0] Sat32 = '1;
endpackage
`default_nettype wire

// File: hw/rtl/cubic_joint_trajectory.sv
// Top level of the cubic point-to-point joint trajectory generator.
// The input channel (in_valid/in_ready) carries load and sample items. A load
// item with joint_index below JOINTS stores that joint's start and goal and
// raises the shared move duration, first cleared when first_joint is set; it
// yields no result and runs two divisions on the shared divider and a 32-step
// square root, no square root when the acceleration quotient saturates, and
// neither when start equals goal. A sample item yields one result per joint on
// the output channel (out_valid/out_ready), last set on the final joint. It
// runs a division for the time ratio and the multiply states S_MR2, S_MW and
// S_PC, then S_JMUL, S_JRES and S_JOUT per joint; with the move finished or
// zero duration it sends each joint's goal through S_JRES and S_JOUT.
// in_ready is high only while no item is in progress, so one item is worked
// on at a time. A stalled receiver holds the current result and the block
// waits. Synchronous reset clears the stored positions and the duration.
`default_nettype none
module cubic_joint_trajectory #(
  parameter int JOINTS = cjt_pkg::JointsDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             command,
  input  wire logic [cjt_pkg::JointFieldW-1:0]  joint_index,
  input  wire logic                             first_joint,
  input  wire logic signed [cjt_pkg::DataW-1:0] start_position,
  input  wire logic signed [cjt_pkg::DataW-1:0] goal_position,
  input  wire logic [cjt_pkg::DataW-1:0]        velocity_limit,
  input  wire logic [cjt_pkg::DataW-1:0]        accel_limit,
  input  wire logic [cjt_pkg::DataW-1:0]        elapsed_time,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [cjt_pkg::JointFieldW-1:0]       out_joint,
  output logic signed [cjt_pkg::DataW-1:0]      setpoint,
  output logic [cjt_pkg::DataW-1:0]             move_duration,
  output logic                                  last
);
  import cjt_pkg::*;

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JW-1:0] LastJoint = JW'(JOINTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_VDIV, S_ADIV, S_SQRT, S_SDIV, S_MR2, S_MW, S_PC, S_JMUL, S_JRES, S_JOUT
  } state_t;

  state_t state;
  logic [DataW-1:0] start_store [JOINTS];
  logic [DataW-1:0] goal_store [JOINTS];
  logic [DataW-1:0] duration;
  logic [DataW-1:0] absdq_r;
  logic [DataW-1:0] accel_limit_r;
  logic [DataW-1:0] ratio;
  logic [DataW-1:0] r2;
  logic [DataW:0]   pval;
  logic             goal_mode;
  logic [JW-1:0]    joint;

  logic             div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic             div_done;
  logic [DivNumW-1:0] div_quo;

  logic [34:0] sq_rem;
  logic [31:0] sq_root;
  logic [63:0] sq_val;
  logic [4:0]  sq_cnt;
  logic [34:0] sq_t;
  logic [34:0] sq_trial;
  logic        sq_fit;

  logic [DataW:0]   mul_a;
  logic [DataW-1:0] mul_b;
  logic [64:0]      mul_prod;

  logic [DataW:0]   in_dq;
  logic [DataW-1:0] in_absdq;
  logic [DataW:0]   j_dq;
  logic [DataW-1:0] j_absdq;
  logic [DataW-1:0] j_start;
  logic [DataW-1:0] j_goal;
  logic [DataW-1:0] vcand;
  logic [33:0]      wval;
  logic [DataW+2:0] psum;
  logic [DataW-1:0] mag;
  logic [DataW-1:0] dur_base;

  function automatic logic [DataW+2:0] in_absdq_r6(input logic [DataW-1:0] a);
    in_absdq_r6 = (DataW+3)'(a) * 35'd6;
  endfunction

  cjt_div #(.NW(DivNumW), .DW(DivDenW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign in_ready = (state == S_IDLE);

  assign in_dq    = {goal_position[DataW-1], goal_position}
                  - {start_position[DataW-1], start_position};
  assign in_absdq = in_dq[DataW] ? DataW'(-in_dq) : in_dq[DataW-1:0];
  assign j_start  = start_store[joint];
  assign j_goal   = goal_store[joint];
  assign j_dq     = {j_goal[DataW-1], j_goal} - {j_start[DataW-1], j_start};
  assign j_absdq  = j_dq[DataW] ? DataW'(-j_dq) : j_dq[DataW-1:0];
  assign vcand    = (div_quo[DivNumW-1:DataW] != '0) ? Sat32 : div_quo[DataW-1:0];
  assign wval     = {2'b11, 32'b0} - {1'b0, ratio, 1'b0};
  assign psum     = (DataW+3)'(r2) * (DataW+3)'(wval[33:32])
                  + (DataW+3)'(mul_prod[63:32]);
  assign mag      = mul_prod[63:32];
  assign dur_base = first_joint ? '0 : duration;

  assign sq_t     = {sq_rem[32:0], sq_val[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_fit   = sq_t >= sq_trial;

  always_comb begin
    unique case (state)
      S_MR2:   begin mul_a = {1'b0, ratio};           mul_b = ratio; end
      S_MW:    begin mul_a = {1'b0, mul_prod[63:32]}; mul_b = wval[31:0]; end
      default: begin mul_a = pval;                    mul_b = j_absdq; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_IDLE && in_valid && command && elapsed_time < duration) begin
      div_start = 1'b1;
      div_num   = {3'b0, elapsed_time, 32'b0};
      div_den   = {1'b0, duration};
    end else if (state == S_IDLE && in_valid && !command) begin
      div_start = 1'b1;
      div_num   = DivNumW'({(DataW+2)'(in_absdq) * 34'd3, 16'b0});
      div_den   = {velocity_limit, 1'b0};
    end else if (state == S_VDIV && div_done) begin
      div_start = 1'b1;
      div_num   = {(DataW+3)'(in_absdq_r6(absdq_r)), 32'b0};
      div_den   = {1'b0, accel_limit_r};
    end
  end

  always_ff @(posedge clk) begin
    mul_prod <= 65'(mul_a) * 65'(mul_b);
    if (rst) begin
      state     <= S_IDLE;
      duration  <= '0;
      out_valid <= 1'b0;
      joint     <= '0;
      goal_mode <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        start_store[i] <= '0;
        goal_store[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            joint <= '0;
            if (command) begin
              if (duration == '0 || elapsed_time >= duration) begin
                goal_mode <= 1'b1;
                state     <= S_JRES;
              end else begin
                goal_mode <= 1'b0;
                state     <= S_SDIV;
              end
            end else if ({29'b0, joint_index} < JOINTS) begin
              start_store[JW'(joint_index)] <= start_position;
              goal_store[JW'(joint_index)]  <= goal_position;
              duration      <= dur_base;
              absdq_r       <= in_absdq;
              accel_limit_r <= accel_limit;
              state         <= (in_absdq == '0) ? S_IDLE : S_VDIV;
            end
          end
        end
        S_VDIV: begin
          if (div_done) begin
            if (vcand > duration) duration <= vcand;
            state <= S_ADIV;
          end
        end
        S_ADIV: begin
          if (div_done) begin
            if (div_quo[DivNumW-1:64] != '0) begin
              duration <= Sat32;
              state    <= S_IDLE;
            end else begin
              sq_val  <= div_quo[63:0];
              sq_rem  <= '0;
              sq_root <= '0;
              sq_cnt  <= '0;
              state   <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          sq_val  <= {sq_val[61:0], 2'b00};
          sq_rem  <= sq_fit ? (sq_t - sq_trial) : sq_t;
          sq_root <= {sq_root[30:0], sq_fit};
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) begin
            if ({sq_root[30:0], sq_fit} > duration) duration <= {sq_root[30:0], sq_fit};
            state <= S_IDLE;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            ratio <= div_quo[DataW-1:0];
            state <= S_MR2;
          end
        end
        S_MR2: state <= S_MW;
        S_MW: begin
          r2    <= mul_prod[63:32];
          state <= S_PC;
        end
        S_PC: begin
          pval  <= (psum > (DataW+3)'(33'h1_0000_0000)) ? 33'h1_0000_0000 : psum[DataW:0];
          state <= S_JMUL;
        end
        S_JMUL: state <= S_JRES;
        S_JRES: begin
          out_valid     <= 1'b1;
          out_joint     <= JointFieldW'(joint);
          move_duration <= duration;
          last          <= (joint == LastJoint);
          if (goal_mode) begin
            setpoint <= j_goal;
          end else begin
            setpoint <= j_dq[DataW] ? (j_start - mag) : (j_start + mag);
          end
          state <= S_JOUT;
        end
        S_JOUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (joint == LastJoint) begin
              state <= S_IDLE;
            end else begin
              joint <= joint + 1'b1;
              state <= goal_mode ? S_JRES : S_JMUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("Input taken while a result is pending.");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> out_joint == JointFieldW'(JOINTS - 1))
    else $error("Last flag on a joint other than the final one.");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(setpoint) && $stable(out_joint))
    else $error("Stalled result changed.");
endmodule
`default_nettype wire

// File: hw/rtl/cjt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module cjt_div #(
  parameter int NW = cjt_pkg::DivNumW,
  parameter int DW = cjt_pkg::DivDenW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  localparam logic [CW-1:0] LastCnt = CW'(NW - 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        quo   <= num;
        rem   <= '0;
        den_r <= den;
      end else if (run) begin
        if (fits) begin
          rem <= DW'(trial - {1'b0, den_r});
        end else begin
          rem <= trial[DW-1:0];
        end
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == LastCnt) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
